// ----- rtl/cact_pkg.sv -----
// ----------------------------------------------------------------------------
// Call arc counter table package
// Word types of the call and arc channels, status codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package cact_pkg;

	typedef struct packed {
		logic [31:0] caller_addr;
		logic [31:0] callee_addr;
	} call_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] arc_count;
		logic [15:0] arc_node;
	} arc_word_t;

	localparam logic [1:0] ST_IGNORED  = 2'd0;
	localparam logic [1:0] ST_COUNTED  = 2'd1;
	localparam logic [1:0] ST_CREATED  = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	localparam logic [1:0] REG_PROFILING_ENABLE = 2'd0;
	localparam logic [1:0] REG_RANGE_LOW        = 2'd1;
	localparam logic [1:0] REG_RANGE_HIGH       = 2'd2;
	localparam logic [1:0] REG_NODE_LIMIT       = 2'd3;

	localparam logic [15:0] NODE_LIMIT_RESET = 16'd4096;

endpackage : cact_pkg

`default_nettype wire

// ----- rtl/call_arc_counter_table_unit.sv -----
// ----------------------------------------------------------------------------
// Call arc counter table
// Counts caller/callee arcs in per-slot binary search trees held in RAM.
// ----------------------------------------------------------------------------
// An accepted call word passes the range check and slot lookup; an ignored word
// goes to the output register, while a counted or new arc walks any tree in its
// slot, one node RAM read per cycle, and a new arc also allocates and links a
// node. The next call word is accepted the cycle after the result is loaded into
// the output register. An overflow result and reset each start a head table
// clearing pass before the next call word; config writes are taken throughout.
`default_nettype none

module call_arc_counter_table_unit #(
	parameter int HEAD_SLOTS = 4096,
	parameter int NODE_SLOTS = 4096
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                call_valid,
	output logic                     call_ready,
	input  wire cact_pkg::call_word_t call_word,
	output logic                     arc_valid,
	input  wire logic                arc_ready,
	output cact_pkg::arc_word_t      arc_word,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [31:0]         cfg_data
);

	localparam int HW        = (HEAD_SLOTS > 1) ? $clog2(HEAD_SLOTS) : 1;
	localparam int NW        = $clog2(NODE_SLOTS);
	localparam int NODE_BITS = 64 + 2 * NW;

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_RANGE = 4'd2;
	localparam logic [3:0] S_SLOT  = 4'd3;
	localparam logic [3:0] S_HEAD  = 4'd4;
	localparam logic [3:0] S_NODE  = 4'd5;
	localparam logic [3:0] S_ALLOC = 4'd6;
	localparam logic [3:0] S_LINK  = 4'd7;
	localparam logic [3:0] S_EMIT  = 4'd8;

	logic [3:0]  state_q;
	logic        enable_q;
	logic [31:0] range_low_q;
	logic [31:0] range_high_q;
	logic [15:0] node_limit_q;

	logic [31:0]          caller_q;
	logic [31:0]          callee_q;
	logic                 in_range_q;
	logic [31:0]          diff_q;
	logic [NW-1:0]        cur_q;
	logic [NODE_BITS-1:0] par_word_q;
	logic                 par_head_q;
	logic                 dir_right_q;
	logic [NW-1:0]        nodes_used_q;
	logic [HW-1:0]        clr_q;
	logic                 clr_after_q;
	logic [1:0]           res_status_q;
	logic [31:0]          res_count_q;
	logic [NW-1:0]        res_node_q;
	logic                 arc_valid_q;
	cact_pkg::arc_word_t  arc_word_q;

	// Head table RAM
	logic          head_we;
	logic [HW-1:0] head_waddr;
	logic [NW-1:0] head_wdata;
	logic          head_re;
	logic [HW-1:0] head_raddr;
	logic [NW-1:0] head_rdata;

	// Node store RAM: {callee, count, left, right}
	logic                 node_we;
	logic [NW-1:0]        node_waddr;
	logic [NODE_BITS-1:0] node_wdata;
	logic                 node_re;
	logic [NW-1:0]        node_raddr;
	logic [NODE_BITS-1:0] node_rdata;

	logic [31:0]   n_callee;
	logic [31:0]   n_count;
	logic [NW-1:0] n_left;
	logic [NW-1:0] n_right;
	logic          hit;
	logic          go_left;
	logic [NW-1:0] next_link;
	logic [31:0]   count_inc;
	logic [15:0]   limit_eff;
	logic [NW:0]   fresh;
	logic          overflow;
	logic          slot_bad;
	logic [HW-1:0] slot;
	logic          out_free;

	cact_ram #(.WIDTH(NW), .DEPTH(HEAD_SLOTS)) u_head_ram (
		.clk   (clk),
		.we    (head_we),
		.waddr (head_waddr),
		.wdata (head_wdata),
		.re    (head_re),
		.raddr (head_raddr),
		.rdata (head_rdata)
	);

	cact_ram #(.WIDTH(NODE_BITS), .DEPTH(NODE_SLOTS)) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wdata),
		.re    (node_re),
		.raddr (node_raddr),
		.rdata (node_rdata)
	);

	assign n_callee  = node_rdata[NODE_BITS-1 -: 32];
	assign n_count   = node_rdata[2*NW +: 32];
	assign n_left    = node_rdata[NW +: NW];
	assign n_right   = node_rdata[0 +: NW];
	assign hit       = (n_callee == callee_q);
	assign go_left   = (callee_q < n_callee);
	assign next_link = go_left ? n_left : n_right;
	assign count_inc = n_count + 32'd1;

	assign limit_eff = (node_limit_q > 16'(NODE_SLOTS)) ? 16'(NODE_SLOTS) : node_limit_q;
	assign fresh     = {1'b0, nodes_used_q} + {{NW{1'b0}}, 1'b1};
	assign overflow  = (17'(fresh) >= {1'b0, limit_eff});

	assign slot_bad = !in_range_q || ({4'b0, diff_q[31:4]} >= 32'(HEAD_SLOTS));
	assign slot     = diff_q[HW+3:4];
	assign out_free = !arc_valid_q || arc_ready;

	assign call_ready = (state_q == S_IDLE);
	assign arc_valid  = arc_valid_q;
	assign arc_word   = arc_word_q;

	always_comb begin
		head_we    = 1'b0;
		head_waddr = slot;
		head_wdata = res_node_q;
		head_re    = 1'b0;
		head_raddr = slot;
		node_we    = 1'b0;
		node_waddr = cur_q;
		node_wdata = par_word_q;
		node_re    = 1'b0;
		node_raddr = next_link;
		unique case (state_q)
			S_CLEAR: begin
				head_we    = 1'b1;
				head_waddr = clr_q;
				head_wdata = '0;
			end
			S_SLOT: begin
				head_re = !slot_bad;
			end
			S_HEAD: begin
				node_re    = (head_rdata != '0);
				node_raddr = head_rdata;
			end
			S_NODE: begin
				if (hit) begin
					node_we    = 1'b1;
					node_wdata = {callee_q, count_inc, n_left, n_right};
				end else begin
					node_re = (next_link != '0);
				end
			end
			S_ALLOC: begin
				node_we    = !overflow;
				node_waddr = fresh[NW-1:0];
				node_wdata = {callee_q, 32'd1, {(2*NW){1'b0}}};
			end
			S_LINK: begin
				if (par_head_q) begin
					head_we = 1'b1;
				end else begin
					node_we = 1'b1;
					if (dir_right_q) begin
						node_wdata = {par_word_q[NODE_BITS-1:NW], res_node_q};
					end else begin
						node_wdata = {par_word_q[NODE_BITS-1:2*NW], res_node_q,
							par_word_q[NW-1:0]};
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q     <= 1'b0;
			range_low_q  <= '0;
			range_high_q <= '0;
			node_limit_q <= cact_pkg::NODE_LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cact_pkg::REG_PROFILING_ENABLE: enable_q     <= cfg_data[0];
				cact_pkg::REG_RANGE_LOW:        range_low_q  <= cfg_data;
				cact_pkg::REG_RANGE_HIGH:       range_high_q <= cfg_data;
				cact_pkg::REG_NODE_LIMIT:       node_limit_q <= cfg_data[15:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			clr_after_q  <= 1'b0;
			nodes_used_q <= '0;
			arc_valid_q  <= 1'b0;
		end else begin
			// While emitting, the output register is either held or reloaded below.
			if (arc_ready && state_q != S_EMIT) begin
				arc_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (clr_q == HW'(HEAD_SLOTS - 1)) begin
						clr_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + HW'(1);
					end
				end
				S_IDLE: begin
					if (call_valid) begin
						caller_q    <= call_word.caller_addr;
						callee_q    <= call_word.callee_addr;
						clr_after_q <= 1'b0;
						state_q     <= S_RANGE;
					end
				end
				S_RANGE: begin
					in_range_q <= enable_q && (caller_q >= range_low_q)
						&& (caller_q <= range_high_q);
					diff_q     <= caller_q - range_low_q;
					state_q    <= S_SLOT;
				end
				S_SLOT: begin
					if (slot_bad) begin
						res_status_q <= cact_pkg::ST_IGNORED;
						res_count_q  <= '0;
						res_node_q   <= '0;
						state_q      <= S_EMIT;
					end else begin
						state_q <= S_HEAD;
					end
				end
				S_HEAD: begin
					cur_q <= head_rdata;
					if (head_rdata == '0) begin
						par_head_q <= 1'b1;
						state_q    <= S_ALLOC;
					end else begin
						state_q <= S_NODE;
					end
				end
				S_NODE: begin
					if (hit) begin
						res_status_q <= cact_pkg::ST_COUNTED;
						res_count_q  <= count_inc;
						res_node_q   <= cur_q;
						state_q      <= S_EMIT;
					end else if (next_link == '0) begin
						// The parent keeps cur_q; its word is kept for the link update.
						par_word_q  <= node_rdata;
						par_head_q  <= 1'b0;
						dir_right_q <= !go_left;
						state_q     <= S_ALLOC;
					end else begin
						cur_q <= next_link;
					end
				end
				S_ALLOC: begin
					if (overflow) begin
						nodes_used_q <= '0;
						clr_after_q  <= 1'b1;
						res_status_q <= cact_pkg::ST_OVERFLOW;
						res_count_q  <= '0;
						res_node_q   <= '0;
						state_q      <= S_EMIT;
					end else begin
						nodes_used_q <= fresh[NW-1:0];
						res_status_q <= cact_pkg::ST_CREATED;
						res_count_q  <= 32'd1;
						res_node_q   <= fresh[NW-1:0];
						state_q      <= S_LINK;
					end
				end
				S_LINK: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						arc_valid_q          <= 1'b1;
						arc_word_q.status    <= res_status_q;
						arc_word_q.arc_count <= res_count_q;
						arc_word_q.arc_node  <= 16'(res_node_q);
						state_q              <= clr_after_q ? S_CLEAR : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule : call_arc_counter_table_unit

`default_nettype wire

// ----- rtl/cact_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module cact_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule : cact_ram

`default_nettype wire

// ----- verif/call_arc_counter_table_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Call arc counter table testbench
// Drives call words with random gaps and output stalls, predicts each arc word
// from a local copy of the head table and node trees, and compares every arc
// word in order against that prediction.
// ----------------------------------------------------------------------------

module call_arc_counter_table_unit_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int HEAD_SLOTS     = 4096;
	localparam int NODE_SLOTS     = 4096;
	localparam int WATCHDOG_LIMIT = 20000;

	logic                 clk;
	logic                 arst_n;
	logic                 call_valid;
	logic                 call_ready;
	cact_pkg::call_word_t call_word;
	logic                 arc_valid;
	logic                 arc_ready;
	cact_pkg::arc_word_t  arc_word;
	logic                 cfg_we;
	logic [1:0]           cfg_index;
	logic [31:0]          cfg_data;

	call_arc_counter_table_unit #(
		.HEAD_SLOTS(HEAD_SLOTS),
		.NODE_SLOTS(NODE_SLOTS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.call_valid(call_valid),
		.call_ready(call_ready),
		.call_word (call_word),
		.arc_valid (arc_valid),
		.arc_ready (arc_ready),
		.arc_word  (arc_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Local copy of the register file and of the arc trees.
	bit          prof_en  = 1'b0;
	logic [31:0] rng_low  = '0;
	logic [31:0] rng_high = '0;
	logic [15:0] node_lim = cact_pkg::NODE_LIMIT_RESET;

	logic [15:0] head_root   [HEAD_SLOTS];
	logic [31:0] node_callee [NODE_SLOTS];
	logic [31:0] node_hits   [NODE_SLOTS];
	logic [15:0] node_left   [NODE_SLOTS];
	logic [15:0] node_right  [NODE_SLOTS];
	int unsigned nodes_used  = 0;

	cact_pkg::arc_word_t expected_arcs[$];
	bit          idle_on       = 1'b1;
	int          rx_long_hold  = 0;
	int unsigned mismatches    = 0;
	int unsigned calls_sent    = 0;
	int unsigned arcs_checked  = 0;
	int unsigned status_seen [4];
	int unsigned deepest_walk  = 0;
	int unsigned settings_used = 0;
	int unsigned quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Walks the callee tree of the caller's slot, bumps or inserts the arc (or clears
	// the trees on overflow) and returns the arc word the block should produce.
	function automatic cact_pkg::arc_word_t count_call_arc(input cact_pkg::call_word_t w);
		cact_pkg::arc_word_t r;
		logic [31:0] slot;
		logic [15:0] cur;
		logic [15:0] parent;
		bit          go_left;
		int unsigned steps;
		int unsigned lim;
		int unsigned fresh;
		r        = '0;
		r.status = cact_pkg::ST_IGNORED;
		if (!prof_en)
			return r;
		if (w.caller_addr < rng_low || w.caller_addr > rng_high)
			return r;
		slot = (w.caller_addr - rng_low) >> 4;
		if (slot >= HEAD_SLOTS)
			return r;
		cur     = head_root[slot];
		parent  = '0;
		go_left = 1'b0;
		steps   = 0;
		while (cur != 0) begin
			if (cur >= NODE_SLOTS || steps > NODE_SLOTS)
				return r;
			steps++;
			if (steps > deepest_walk)
				deepest_walk = steps;
			if (node_callee[cur] == w.callee_addr) begin
				node_hits[cur] = node_hits[cur] + 32'd1;
				r.status    = cact_pkg::ST_COUNTED;
				r.arc_count = node_hits[cur];
				r.arc_node  = cur;
				return r;
			end
			parent  = cur;
			go_left = w.callee_addr < node_callee[cur];
			cur     = go_left ? node_left[cur] : node_right[cur];
		end
		lim = node_lim;
		if (lim > NODE_SLOTS)
			lim = NODE_SLOTS;
		fresh = nodes_used + 1;
		if (fresh >= lim) begin
			foreach (head_root[i])
				head_root[i] = '0;
			nodes_used = 0;
			r.status   = cact_pkg::ST_OVERFLOW;
			return r;
		end
		nodes_used         = fresh;
		node_callee[fresh] = w.callee_addr;
		node_hits[fresh]   = 32'd1;
		node_left[fresh]   = '0;
		node_right[fresh]  = '0;
		if (parent == 0)
			head_root[slot] = fresh[15:0];
		else if (go_left)
			node_left[parent] = fresh[15:0];
		else
			node_right[parent] = fresh[15:0];
		r.status    = cact_pkg::ST_CREATED;
		r.arc_count = 32'd1;
		r.arc_node  = fresh[15:0];
		return r;
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			cact_pkg::REG_PROFILING_ENABLE: prof_en  = data[0];
			cact_pkg::REG_RANGE_LOW:        rng_low  = data;
			cact_pkg::REG_RANGE_HIGH:       rng_high = data;
			cact_pkg::REG_NODE_LIMIT:       node_lim = data[15:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input bit en, input logic [31:0] lo, input logic [31:0] hi,
		input logic [15:0] lim);
		write_reg(cact_pkg::REG_PROFILING_ENABLE, {31'd0, en});
		write_reg(cact_pkg::REG_RANGE_LOW, lo);
		write_reg(cact_pkg::REG_RANGE_HIGH, hi);
		write_reg(cact_pkg::REG_NODE_LIMIT, {16'd0, lim});
		settings_used++;
	endtask

	// Valid is left high on return so that a back-to-back word needs no toggle.
	task automatic send_call(input logic [31:0] caller, input logic [31:0] callee);
		cact_pkg::call_word_t w;
		int         gap;
		w.caller_addr = caller;
		w.callee_addr = callee;
		gap = pick_gap();
		if (gap > 0) begin
			call_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		call_valid <= 1'b1;
		call_word  <= w;
		do
			@(posedge clk);
		while (!call_ready);
		expected_arcs.push_back(count_call_arc(w));
		calls_sent++;
	endtask

	task automatic wait_arcs_drained();
		call_valid <= 1'b0;
		@(posedge clk);
		while (expected_arcs.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_reset_defaults();
		send_call(32'h0, 32'h0);
		send_call($urandom, $urandom);
		wait_arcs_drained();
		// Only the enable is written, so the range is still the single address zero.
		write_reg(cact_pkg::REG_PROFILING_ENABLE, 32'd1);
		send_call(32'h0, 32'h1234);
		send_call(32'h1, 32'h1234);
		wait_arcs_drained();
	endtask

	task automatic test_directed_cases();
		set_config(1'b1, 32'h0, 32'hFFFF_FFFF, cact_pkg::NODE_LIMIT_RESET);
		send_call(32'h0, 32'h0);
		send_call(32'h0, 32'h0);
		send_call(32'hF, 32'hFFFF_FFFF);
		send_call(32'hFFF0, 32'h0);
		send_call(32'h1_0000, 32'h0);
		send_call(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		wait_arcs_drained();
		set_config(1'b1, 32'h1000, 32'h1FFF, cact_pkg::NODE_LIMIT_RESET);
		send_call(32'hFFF, 32'h0);
		send_call(32'h2000, 32'h0);
		send_call(32'h1FFF, 32'h0);
		send_call(32'h1000, 32'hFFFF_FFFF);
		wait_arcs_drained();
		// An unaligned low bound is used as written.
		set_config(1'b1, 32'h1008, 32'hFFFF_FFFF, cact_pkg::NODE_LIMIT_RESET);
		send_call(32'h1017, 32'h0);
		wait_arcs_drained();
		set_config(1'b1, 32'h100, 32'hFF, cact_pkg::NODE_LIMIT_RESET);
		send_call(32'h100, 32'h0);
		wait_arcs_drained();
		set_config(1'b0, 32'h0, 32'hFFFF_FFFF, cact_pkg::NODE_LIMIT_RESET);
		send_call(32'h0, 32'h0);
		wait_arcs_drained();
		// Ascending callees build a right-leaning chain, descending ones a left one.
		set_config(1'b1, 32'h0, 32'hFFFF_FFFF, cact_pkg::NODE_LIMIT_RESET);
		for (int i = 1; i <= 6; i++)
			send_call(32'h70, i);
		send_call(32'h7C, 32'd6);
		send_call(32'h80, 32'd100);
		send_call(32'h80, 32'd50);
		send_call(32'h80, 32'd10);
		send_call(32'h84, 32'd10);
		wait_arcs_drained();
	endtask

	task automatic test_node_limit_overflow();
		set_config(1'b1, 32'h0, 32'hFFFF_FFFF, 16'd4);
		send_call(32'h140, 32'd11);
		send_call(32'h140, 32'd11);
		send_call(32'h140, 32'd22);
		send_call(32'h140, 32'd33);
		send_call(32'h140, 32'd44);
		send_call(32'h140, 32'd11);
		wait_arcs_drained();
		set_config(1'b1, 32'h0, 32'hFFFF_FFFF, 16'd1);
		send_call(32'h150, 32'd5);
		wait_arcs_drained();
		set_config(1'b1, 32'h0, 32'hFFFF_FFFF, 16'd2);
		send_call(32'h150, 32'd6);
		send_call(32'h150, 32'd7);
		send_call(32'h150, 32'd6);
		wait_arcs_drained();
		set_config(1'b1, 32'h0, 32'hFFFF_FFFF, 16'hFFFF);
		send_call(32'h150, 32'd1);
		wait_arcs_drained();
	endtask

	task automatic test_output_stall();
		set_config(1'b1, 32'h0, 32'hFFFF_FFFF, cact_pkg::NODE_LIMIT_RESET);
		idle_on      = 1'b0;
		rx_long_hold = 300;
		for (int i = 0; i < 12; i++)
			send_call(32'h1E0 + ((i % 3) << 4), $urandom_range(0, 3));
		wait_arcs_drained();
		idle_on = 1'b1;
	endtask

	// Mostly well-formed traffic: a few slots and a small callee pool so that
	// arcs repeat and trees grow; the rest is out-of-range and random noise.
	task automatic run_random_phase(input int n_items);
		logic [31:0] callee_pool [10];
		logic [31:0] slot_pick [4];
		logic [31:0] max_slot;
		logic [31:0] caller;
		logic [31:0] callee;
		int          kind;
		foreach (callee_pool[k])
			callee_pool[k] = $urandom;
		callee_pool[0] = '0;
		callee_pool[1] = '1;
		max_slot = (rng_high >= rng_low) ? (rng_high - rng_low) >> 4 : '0;
		if (max_slot > HEAD_SLOTS - 1)
			max_slot = HEAD_SLOTS - 1;
		foreach (slot_pick[k])
			slot_pick[k] = $urandom_range(0, max_slot);
		slot_pick[0] = '0;
		slot_pick[3] = max_slot;
		for (int i = 0; i < n_items; i++) begin
			kind   = $urandom_range(0, 99);
			callee = callee_pool[$urandom_range(0, 9)];
			if (kind < 78) begin
				caller = rng_low + (slot_pick[$urandom_range(0, 3)] << 4)
					+ $urandom_range(0, 15);
			end else if (kind < 86) begin
				caller = $urandom;
				callee = $urandom;
			end else if (kind < 93) begin
				caller = ($urandom_range(0, 1) && rng_low != 0) ? rng_low - 1 : rng_high + 1;
			end else begin
				caller = rng_low + (HEAD_SLOTS << 4) + $urandom_range(0, 255);
			end
			send_call(caller, callee);
		end
	endtask

	task automatic test_random_traffic();
		logic [31:0] lo;
		logic [32:0] top;
		for (int p = 0; p < 6; p++) begin
			wait_arcs_drained();
			idle_on = (p != 1);
			case (p)
				0: set_config(1'b1, 32'h0, 32'hFFFF_FFFF, 16'd8);
				1: begin
					lo  = $urandom & 32'hFFFF_FFF0;
					top = {1'b0, lo} + 33'h3FF;
					set_config(1'b1, lo, top[32] ? 32'hFFFF_FFFF : top[31:0],
						cact_pkg::NODE_LIMIT_RESET);
				end
				2: begin
					lo  = $urandom;
					top = {1'b0, lo} + $urandom_range(0, 32'h1_FFFF);
					set_config(1'b1, lo, top[32] ? 32'hFFFF_FFFF : top[31:0], 16'd3);
				end
				3: set_config(1'b1, 32'hFFFF_F000, 32'hFFFF_FFFF, 16'hFFFF);
				4: set_config(1'b1, 32'h4000_0000, 32'h4000_FFFF, 16'($urandom_range(2, 64)));
				default: set_config(1'b1, 32'h10, 32'hFFFF_FFFE, 16'd2);
			endcase
			run_random_phase(70);
		end
		idle_on = 1'b1;
	endtask

	initial begin
		arst_n     <= 1'b0;
		call_valid <= 1'b0;
		call_word  <= '0;
		cfg_we     <= 1'b0;
		cfg_index  <= cact_pkg::REG_PROFILING_ENABLE;
		cfg_data   <= '0;
		foreach (head_root[i])
			head_root[i] = '0;
		foreach (status_seen[i])
			status_seen[i] = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_directed_cases();
		test_node_limit_overflow();
		test_output_stall();
		test_random_traffic();

		wait_arcs_drained();
		repeat (20) @(posedge clk);
		mismatches += expected_arcs.size();
		$display("covered %0d call words over %0d register settings, deepest tree walk %0d",
			calls_sent, settings_used, deepest_walk);
		$display("arc words: %0d ignored, %0d counted, %0d created, %0d overflow",
			status_seen[cact_pkg::ST_IGNORED], status_seen[cact_pkg::ST_COUNTED],
			status_seen[cact_pkg::ST_CREATED], status_seen[cact_pkg::ST_OVERFLOW]);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Output side: random stalls, plus a long hold-off when a test asks for one.
	initial begin
		int rx_hold;
		rx_hold = 0;
		arc_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rx_long_hold > 0) begin
				rx_hold      = rx_long_hold;
				rx_long_hold = 0;
			end
			if (rx_hold > 0) begin
				arc_ready <= 1'b0;
				rx_hold--;
			end else begin
				arc_ready <= 1'b1;
				if ($urandom_range(0, 99) < 20)
					rx_hold = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		cact_pkg::arc_word_t want;
		if (arst_n && arc_valid && arc_ready) begin
			arcs_checked++;
			status_seen[arc_word.status]++;
			if (expected_arcs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: arc word with nothing pending: status %0d count %0d node %0d",
						$realtime, arc_word.status, arc_word.arc_count, arc_word.arc_node);
			end else begin
				want = expected_arcs.pop_front();
				if (arc_word.status !== want.status || arc_word.arc_count !== want.arc_count ||
					arc_word.arc_node !== want.arc_node) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"%0t: arc word %0d: expected status %0d count %0d node %0d,",
							" got status %0d count %0d node %0d"},
							$realtime, arcs_checked, want.status, want.arc_count,
							want.arc_node, arc_word.status, arc_word.arc_count,
							arc_word.arc_node);
				end
			end
		end
	end

	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((call_valid && call_ready) || (arc_valid && arc_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("watchdog: no word moved for %0d cycles, %0d arc words still pending",
			WATCHDOG_LIMIT, expected_arcs.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
